FILE: hw/rtl/tunnel_peer_table_core_assert.svh
// Assertion macros for the tunnel peer table core
`ifndef TUNNEL_PEER_TABLE_CORE_ASSERT_SVH
`define TUNNEL_PEER_TABLE_CORE_ASSERT_SVH
`define TPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TPT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

FILE: hw/rtl/tpt_pkg.sv
// Package: types and constants of the tunnel peer table
package tpt_pkg;
  localparam int unsigned TableEntries = 8;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [15:0] FrameOverhead = 16'd44;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_DEL = 2'd1, OP_SEND = 2'd2, OP_RECV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_BAD_SLOT = 3'd2, ST_SHORT = 3'd3, ST_NO_MATCH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_SCAN_BOTH, BK_SCAN_TAG, BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  slot_index;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] peer_tag;
    logic [15:0] length_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [63:0] nonce_count;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] tag_out;
    logic [15:0] length_out;
    logic        address_matched;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e         op;
    logic        idx_ok;
    logic        short_pkt;
    logic [15:0] len_calc;
    in_item_t    item;
  } cmd_t;
endpackage

FILE: hw/rtl/tunnel_peer_table_core.sv
// Top level of the tunnel peer table core
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | in_item_i
// out     | output    | out_valid / out_stall | out_item_o
// Add, delete, send and a too-short receive go straight to the done state, which raises
// out_valid; other receives first scan one entry per cycle for tag+address, then tag only.
// Reset clears all valid bits at once; entry data is not reset.
// A two-entry command queue lets the front accept items while the back works
// or its result waits under out_stall.
module tunnel_peer_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpt_pkg::in_item_t  in_item_i,
  output logic               out_valid,
  input  logic               out_stall,
  output tpt_pkg::out_item_t out_item_o
);
  import tpt_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  tpt_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  tpt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid, .out_stall, .out_item_o
  );
endmodule

FILE: hw/rtl/tpt_front.sv
// Front part: accept items, classify them and queue commands
module tpt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_stall,
  input  tpt_pkg::in_item_t in_item_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output tpt_pkg::cmd_t    cmd_o
);
  import tpt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            fifo_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  cmd_t            cmd_new;
  logic [16:0]     sum;
  logic            push;

  always_comb begin
    sum = {1'b0, in_item_i.length_in} + {1'b0, FrameOverhead};
    cmd_new.op = op_e'(in_item_i.operation);
    cmd_new.item = in_item_i;
    cmd_new.idx_ok = ({29'd0, in_item_i.slot_index} < 32'(TableEntries));
    cmd_new.short_pkt = in_item_i.length_in < FrameOverhead;
    if (cmd_new.op == OP_SEND) begin
      cmd_new.len_calc = sum[16] ? 16'hFFFF : sum[15:0];
    end else begin
      cmd_new.len_calc = in_item_i.length_in - FrameOverhead;
    end
  end

  assign in_stall = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push = in_valid && !in_stall;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = fifo_q[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = cmd_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_new;
    end
  end

`include "tunnel_peer_table_core_assert.svh"
  `TPT_ASSERT_NEVER(a_no_pop_empty, cmd_pop_i && cnt_q == '0, "pop from empty queue")
  `TPT_ASSERT(a_cnt_range, cnt_q <= (PtrW+1)'(QueueDepth), "queue count overflow")
  `TPT_ASSERT(a_full_stalls, cnt_q == (PtrW+1)'(QueueDepth) |-> in_stall, "full queue not stalling")
endmodule

FILE: hw/rtl/tpt_back.sv
// Back part: execute queued commands against the peer table
module tpt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  tpt_pkg::cmd_t      cmd_i,
  output logic               out_valid,
  input  logic               out_stall,
  output tpt_pkg::out_item_t out_item_o
);
  import tpt_pkg::*;

  logic [TableEntries-1:0] valid_q, valid_d;
  logic [31:0] addr_q  [TableEntries];
  logic [15:0] rport_q [TableEntries];
  logic [15:0] lport_q [TableEntries];
  logic [31:0] tag_q   [TableEntries];
  logic [63:0] nonce_q [TableEntries];

  back_state_e state_q, state_d;
  logic [IdxW-1:0] scan_q, scan_d;
  out_item_t res_q, res_d;
  logic ov_q, ov_d;
  logic [IdxW-1:0] free_idx;
  logic free_any;
  logic [IdxW-1:0] sidx;
  logic slot_ok;
  logic wr_add, inc_nonce;
  logic tag_hit, addr_hit, last;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign sidx = cmd_i.item.slot_index[IdxW-1:0];
  assign slot_ok = cmd_i.idx_ok && valid_q[sidx];
  assign tag_hit = valid_q[scan_q] && (tag_q[scan_q] == cmd_i.item.peer_tag);
  assign addr_hit = addr_q[scan_q] == cmd_i.item.peer_address;
  assign last = (scan_q == IdxW'(TableEntries - 1));
  assign out_valid = ov_q;
  assign out_item_o = res_q;

  always_comb begin
    state_d = state_q;
    scan_d = scan_q;
    res_d = res_q;
    ov_d = ov_q && out_stall;
    valid_d = valid_q;
    cmd_pop_o = 1'b0;
    wr_add = 1'b0;
    inc_nonce = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !ov_d) begin
          res_d = '0;
          scan_d = '0;
          state_d = BK_DONE;
          case (cmd_i.op)
            OP_ADD: begin
              if (free_any) begin
                wr_add = 1'b1;
                valid_d[free_idx] = 1'b1;
                res_d.slot_out = 3'(free_idx);
              end else begin
                res_d.status = ST_FULL;
              end
            end
            OP_DEL: begin
              if (slot_ok) begin
                valid_d[sidx] = 1'b0;
                res_d.slot_out = cmd_i.item.slot_index;
              end else begin
                res_d.status = ST_BAD_SLOT;
              end
            end
            OP_SEND: begin
              if (slot_ok) begin
                inc_nonce = 1'b1;
                res_d.slot_out = cmd_i.item.slot_index;
                res_d.nonce_count = nonce_q[sidx];
                res_d.dest_address = addr_q[sidx];
                res_d.dest_port = rport_q[sidx];
                res_d.source_port = lport_q[sidx];
                res_d.tag_out = tag_q[sidx];
                res_d.length_out = cmd_i.len_calc;
              end else begin
                res_d.status = ST_BAD_SLOT;
              end
            end
            OP_RECV: begin
              if (cmd_i.short_pkt) begin
                res_d.status = ST_SHORT;
              end else begin
                state_d = BK_SCAN_BOTH;
              end
            end
            default: res_d.status = ST_BAD_SLOT;
          endcase
        end
      end
      BK_SCAN_BOTH: begin
        if (tag_hit && addr_hit) begin
          res_d.slot_out = 3'(scan_q);
          res_d.length_out = cmd_i.len_calc;
          res_d.address_matched = 1'b1;
          state_d = BK_DONE;
        end else if (last) begin
          scan_d = '0;
          state_d = BK_SCAN_TAG;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      BK_SCAN_TAG: begin
        if (tag_hit) begin
          res_d.slot_out = 3'(scan_q);
          res_d.length_out = cmd_i.len_calc;
          state_d = BK_DONE;
        end else if (last) begin
          res_d.status = ST_NO_MATCH;
          state_d = BK_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      BK_DONE: begin
        ov_d = 1'b1;
        cmd_pop_o = 1'b1;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= '0;
      ov_q <= 1'b0;
      scan_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      ov_q <= ov_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (wr_add) begin
      addr_q[free_idx] <= cmd_i.item.peer_address;
      rport_q[free_idx] <= cmd_i.item.peer_port;
      lport_q[free_idx] <= cmd_i.item.own_port;
      tag_q[free_idx] <= cmd_i.item.peer_tag;
      nonce_q[free_idx] <= 64'd1;
    end
    if (inc_nonce) begin
      nonce_q[sidx] <= nonce_q[sidx] + 64'd1;
    end
  end

`include "tunnel_peer_table_core_assert.svh"
  `TPT_ASSERT(a_hold_out, out_valid && out_stall |=> out_valid && $stable(out_item_o), "result dropped")
  `TPT_ASSERT(a_pop_done, cmd_pop_o |-> state_q == BK_DONE && cmd_valid_i, "pop outside done")
  `TPT_ASSERT(a_scan_recv, state_q == BK_SCAN_BOTH |-> cmd_i.op == OP_RECV, "scan without receive")
endmodule

FILE: test/tb_tunnel_peer_table_core.sv
// Testbench for the tunnel peer table core: directed table plus random items against a predictor
`timescale 1ns / 100ps

module tb_tunnel_peer_table_core;
  import tpt_pkg::*;

  localparam int NumRandom = 530;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item_i;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item_o;

  tunnel_peer_table_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item_i  (in_item_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item_o (out_item_o)
  );

  // peer table shadow
  logic        peer_valid [TableEntries];
  logic [31:0] peer_addr  [TableEntries];
  logic [15:0] peer_rport [TableEntries];
  logic [15:0] peer_lport [TableEntries];
  logic [31:0] peer_id    [TableEntries];
  logic [63:0] peer_nonce [TableEntries];

  out_item_t pending_results[$];
  int        error_count;
  logic      rx_hold;
  logic      quiet_mode;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic out_item_t apply_peer_op(in_item_t it);
    out_item_t r;
    logic [16:0] total;
    int hit;
    logic both;
    r = '0;
    hit = -1;
    both = 1'b0;
    case (op_e'(it.operation))
      OP_ADD: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (hit < 0 && !peer_valid[i]) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          peer_valid[hit] = 1'b1;
          peer_addr[hit]  = it.peer_address;
          peer_rport[hit] = it.peer_port;
          peer_lport[hit] = it.own_port;
          peer_id[hit]    = it.peer_tag;
          peer_nonce[hit] = 64'd1;
          r.slot_out = hit[2:0];
        end
      end
      OP_DEL: begin
        if (!peer_valid[it.slot_index]) begin
          r.status = ST_BAD_SLOT;
        end else begin
          peer_valid[it.slot_index] = 1'b0;
          r.slot_out = it.slot_index;
        end
      end
      OP_SEND: begin
        if (!peer_valid[it.slot_index]) begin
          r.status = ST_BAD_SLOT;
        end else begin
          total = {1'b0, it.length_in} + 17'd44;
          r.slot_out     = it.slot_index;
          r.nonce_count  = peer_nonce[it.slot_index];
          r.dest_address = peer_addr[it.slot_index];
          r.dest_port    = peer_rport[it.slot_index];
          r.source_port  = peer_lport[it.slot_index];
          r.tag_out      = peer_id[it.slot_index];
          r.length_out   = total[16] ? 16'hFFFF : total[15:0];
          peer_nonce[it.slot_index] = peer_nonce[it.slot_index] + 64'd1;
        end
      end
      default: begin
        if (it.length_in < FrameOverhead) begin
          r.status = ST_SHORT;
        end else begin
          for (int i = 0; i < TableEntries; i++) begin
            if (hit < 0 && peer_valid[i] && peer_id[i] == it.peer_tag &&
                peer_addr[i] == it.peer_address) begin
              hit = i;
              both = 1'b1;
            end
          end
          for (int i = 0; i < TableEntries; i++) begin
            if (hit < 0 && peer_valid[i] && peer_id[i] == it.peer_tag) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NO_MATCH;
          end else begin
            r.slot_out        = hit[2:0];
            r.length_out      = it.length_in - FrameOverhead;
            r.address_matched = both;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // send one item, hold it until accepted
  task automatic send_item(in_item_t it, logic check_fixed, out_item_t fixed);
    out_item_t r;
    if (!quiet_mode && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    in_item_i <= it;
    r = apply_peer_op(it);
    if (check_fixed && r != fixed)
      report_mismatch("predictor vs table", {58'd0, r.status, r.slot_out},
                      {58'd0, fixed.status, fixed.slot_out});
    pending_results.push_back(r);
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // output monitor and checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 64'd0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status != want.status)
          report_mismatch("status", 64'(out_item_o.status), 64'(want.status));
        if (out_item_o.slot_out != want.slot_out)
          report_mismatch("slot_out", 64'(out_item_o.slot_out), 64'(want.slot_out));
        if (out_item_o.nonce_count != want.nonce_count)
          report_mismatch("nonce_count", out_item_o.nonce_count, want.nonce_count);
        if (out_item_o.dest_address != want.dest_address)
          report_mismatch("dest_address", 64'(out_item_o.dest_address),
                          64'(want.dest_address));
        if (out_item_o.dest_port != want.dest_port)
          report_mismatch("dest_port", 64'(out_item_o.dest_port), 64'(want.dest_port));
        if (out_item_o.source_port != want.source_port)
          report_mismatch("source_port", 64'(out_item_o.source_port),
                          64'(want.source_port));
        if (out_item_o.tag_out != want.tag_out)
          report_mismatch("tag_out", 64'(out_item_o.tag_out), 64'(want.tag_out));
        if (out_item_o.length_out != want.length_out)
          report_mismatch("length_out", 64'(out_item_o.length_out), 64'(want.length_out));
        if (out_item_o.address_matched != want.address_matched)
          report_mismatch("address_matched", 64'(out_item_o.address_matched),
                          64'(want.address_matched));
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (rx_hold) out_stall <= 1'b1;
    else if (quiet_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 12);
  end

  function automatic in_item_t make_item(op_e op, logic [2:0] idx, logic [31:0] addr,
                                         logic [31:0] tag, logic [15:0] len);
    in_item_t it;
    it.operation    = op;
    it.slot_index   = idx;
    it.peer_address = addr;
    it.peer_port    = 16'($urandom());
    it.own_port     = 16'($urandom());
    it.peer_tag     = tag;
    it.length_in    = len;
    return it;
  endfunction

  function automatic out_item_t status_only(status_e st, logic [2:0] slot);
    out_item_t r;
    r = '0;
    r.status = st;
    r.slot_out = slot;
    return r;
  endfunction

  typedef struct {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } directed_row_t;

  directed_row_t directed[$];
  in_item_t      it;
  logic [31:0]   tag_pool[4];
  logic [31:0]   addr_pool[4];
  int            wait_cycles;

  initial begin
    error_count = 0;
    rx_hold = 1'b0;
    quiet_mode = 1'b0;
    in_valid = 1'b0;
    in_item_i = '0;
    for (int i = 0; i < TableEntries; i++) begin
      peer_valid[i] = 1'b0;
      peer_nonce[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    directed.push_back('{make_item(OP_SEND, 3'd0, '0, '0, '0), 1'b1,
                         status_only(ST_BAD_SLOT, 3'd0)});
    directed.push_back('{make_item(OP_DEL, 3'd7, '0, '0, '0), 1'b1,
                         status_only(ST_BAD_SLOT, 3'd0)});
    directed.push_back('{make_item(OP_RECV, 3'd0, '0, '0, 16'd43), 1'b1,
                         status_only(ST_SHORT, 3'd0)});
    directed.push_back('{make_item(OP_RECV, 3'd0, '0, '0, 16'd44), 1'b1,
                         status_only(ST_NO_MATCH, 3'd0)});
    for (int i = 0; i < TableEntries; i++) begin
      directed.push_back('{make_item(OP_ADD, 3'd0, i[0] ? 32'hFFFF_FFFF : 32'h0,
                                     i < 2 ? 32'h1234_5678 : (i[0] ? 32'hFFFF_FFFF : 32'h0),
                                     '0), 1'b1, status_only(ST_OK, i[2:0])});
    end
    directed.push_back('{make_item(OP_ADD, 3'd0, '0, '0, '0), 1'b1,
                         status_only(ST_FULL, 3'd0)});
    directed.push_back('{make_item(OP_SEND, 3'd7, '0, '0, 16'hFFFF), 1'b0, '0});
    directed.push_back('{make_item(OP_SEND, 3'd7, '0, '0, 16'hFFD3), 1'b0, '0});
    directed.push_back('{make_item(OP_SEND, 3'd0, '0, '0, 16'd0), 1'b0, '0});
    directed.push_back('{make_item(OP_RECV, 3'd0, 32'hFFFF_FFFF, 32'h1234_5678, 16'd44),
                         1'b0, '0});
    directed.push_back('{make_item(OP_RECV, 3'd0, 32'h5, 32'h1234_5678, 16'hFFFF), 1'b0, '0});
    directed.push_back('{make_item(OP_RECV, 3'd0, 32'h5, 32'hAAAA_5555, 16'd100), 1'b1,
                         status_only(ST_NO_MATCH, 3'd0)});
    directed.push_back('{make_item(OP_DEL, 3'd7, '0, '0, '0), 1'b1, status_only(ST_OK, 3'd7)});
    directed.push_back('{make_item(OP_DEL, 3'd7, '0, '0, '0), 1'b1,
                         status_only(ST_BAD_SLOT, 3'd0)});
    directed.push_back('{make_item(OP_DEL, 3'd0, '0, '0, '0), 1'b1, status_only(ST_OK, 3'd0)});
    directed.push_back('{make_item(OP_RECV, 3'd0, 32'h0, 32'h1234_5678, 16'd60), 1'b0, '0});
    foreach (directed[k]) send_item(directed[k].item, directed[k].fixed, directed[k].want);

    // random part; long quiet stretch, and one long receiver hold-off
    for (int i = 0; i < 4; i++) begin
      tag_pool[i] = $urandom();
      addr_pool[i] = $urandom();
    end
    tag_pool[3] = 32'hFFFF_FFFF;
    addr_pool[3] = 32'hFFFF_FFFF;
    fork
      begin
        repeat (100) @(posedge clk_i);
        rx_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    for (int n = 0; n < NumRandom; n++) begin
      quiet_mode = (n >= 150 && n < 250);
      it = make_item(op_e'($urandom_range(3)), 3'($urandom_range(7)),
                     $urandom_range(9) == 0 ? $urandom() : addr_pool[$urandom_range(3)],
                     $urandom_range(9) == 0 ? $urandom() : tag_pool[$urandom_range(3)],
                     16'($urandom_range(3) == 0 ? $urandom() : $urandom_range(120)));
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
    quiet_mode = 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * TableEntries + 10) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
